[rtl/irenc_pkg.sv]
// package: shared types, constants and microcode table for the roman numeral encoder
`default_nettype none

package irenc_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 8;
    localparam int WEIGHT_W = 10;
    localparam int STEP_CNT = 13;
    localparam int PC_W     = $clog2(STEP_CNT);

    localparam logic [SYMBOL_W-1:0] CH_I = 8'h49;
    localparam logic [SYMBOL_W-1:0] CH_V = 8'h56;
    localparam logic [SYMBOL_W-1:0] CH_X = 8'h58;
    localparam logic [SYMBOL_W-1:0] CH_L = 8'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_D = 8'h44;
    localparam logic [SYMBOL_W-1:0] CH_M = 8'h4D;
    localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;

    // one control word per step
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [SYMBOL_W-1:0] first;
        logic [SYMBOL_W-1:0] second;
        logic                pair;
        logic                final_step;
    } ucode_t;

    // datapath controls
    typedef struct packed {
        logic load;
        logic sub;
    } dp_ctrl_t;

    // datapath flags
    typedef struct packed {
        logic ge;
        logic diff_zero;
        logic rest_zero;
    } dp_status_t;

    function automatic ucode_t ucode_fetch(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{10'd1000, CH_M, CH_NONE, 1'b0, 1'b0};
            4'd1:    w = '{10'd900,  CH_C, CH_M,    1'b1, 1'b0};
            4'd2:    w = '{10'd500,  CH_D, CH_NONE, 1'b0, 1'b0};
            4'd3:    w = '{10'd400,  CH_C, CH_D,    1'b1, 1'b0};
            4'd4:    w = '{10'd100,  CH_C, CH_NONE, 1'b0, 1'b0};
            4'd5:    w = '{10'd90,   CH_X, CH_C,    1'b1, 1'b0};
            4'd6:    w = '{10'd50,   CH_L, CH_NONE, 1'b0, 1'b0};
            4'd7:    w = '{10'd40,   CH_X, CH_L,    1'b1, 1'b0};
            4'd8:    w = '{10'd10,   CH_X, CH_NONE, 1'b0, 1'b0};
            4'd9:    w = '{10'd9,    CH_I, CH_X,    1'b1, 1'b0};
            4'd10:   w = '{10'd5,    CH_V, CH_NONE, 1'b0, 1'b0};
            4'd11:   w = '{10'd4,    CH_I, CH_V,    1'b1, 1'b0};
            4'd12:   w = '{10'd1,    CH_I, CH_NONE, 1'b0, 1'b1};
            default: w = '{10'd1,    CH_I, CH_NONE, 1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/integer_to_roman_encoder_unit.sv]
// top level: integer to roman numeral encoder, one ascii letter per output item
`default_nettype none

// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------
// input     | item_valid / item_stall  | value[11:0]
// output    | char_valid / char_stall  | symbol[7:0], last
//
// one number at a time: item_stall is high from acceptance until the last
// letter has been loaded into the output register
// a fitting weight emits one letter per cycle while the output is not stalled,
// and a weight that does not fit moves the sequencer on to the next step
// zero is accepted and produces no item
// output stall holds the output register and freezes the sequencer on emit steps
// rst_n clears the sequencer and output valid asynchronously

module integer_to_roman_encoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [irenc_pkg::VALUE_W-1:0]   value,
    // output channel
    output logic                                 char_valid,
    input  wire logic                            char_stall,
    output logic [irenc_pkg::SYMBOL_W-1:0]       symbol,
    output logic                                 last
);

    logic [irenc_pkg::PC_W-1:0] pc;
    irenc_pkg::ucode_t          word;
    irenc_pkg::dp_ctrl_t        ctrl;
    irenc_pkg::dp_status_t      status;
    logic                       value_zero;

    // zero input has no letters, so the sequencer stays idle
    assign value_zero = (value == '0);

    // control store: weight, letters and jump flags per step
    irenc_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    // remainder register with compare and subtract
    irenc_datapath u_dp (
        .clk    (clk),
        .ctrl   (ctrl),
        .value  (value),
        .weight (word.weight),
        .status (status)
    );

    // step counter, letter phase and output register
    irenc_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value_zero (value_zero),
        .pc         (pc),
        .word       (word),
        .ctrl       (ctrl),
        .status     (status),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .symbol     (symbol),
        .last       (last)
    );

endmodule

`default_nettype wire

[rtl/irenc_ucode_rom.sv]
// microcode store: control word for the current step
`default_nettype none

module irenc_ucode_rom (
    input  wire logic [irenc_pkg::PC_W-1:0] pc,
    output irenc_pkg::ucode_t               word
);

    assign word = irenc_pkg::ucode_fetch(pc);

endmodule

`default_nettype wire

[rtl/irenc_datapath.sv]
// datapath: remainder register with compare and subtract against the step weight
`default_nettype none

module irenc_datapath (
    input  wire logic                             clk,
    input  wire irenc_pkg::dp_ctrl_t              ctrl,
    input  wire logic [irenc_pkg::VALUE_W-1:0]    value,
    input  wire logic [irenc_pkg::WEIGHT_W-1:0]   weight,
    output irenc_pkg::dp_status_t                 status
);

    logic [irenc_pkg::VALUE_W-1:0] rest_reg;
    logic [irenc_pkg::VALUE_W-1:0] rest_next;
    logic [irenc_pkg::VALUE_W-1:0] weight_ext;
    logic [irenc_pkg::VALUE_W-1:0] diff;

    assign weight_ext = {{(irenc_pkg::VALUE_W-irenc_pkg::WEIGHT_W){1'b0}}, weight};
    assign diff       = rest_reg - weight_ext;

    assign status.ge        = (rest_reg >= weight_ext);
    assign status.diff_zero = (diff == '0);
    assign status.rest_zero = (rest_reg == '0);

    always_comb
    begin
        rest_next = rest_reg;
        if (ctrl.load)
        begin
            rest_next = value;
        end
        else if (ctrl.sub)
        begin
            rest_next = diff;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
    end

endmodule

`default_nettype wire

[rtl/irenc_sequencer.sv]
// sequencer: step counter, conditional jumps and the output register
`default_nettype none

module irenc_sequencer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic                             value_zero,
    output logic [irenc_pkg::PC_W-1:0]            pc,
    input  wire irenc_pkg::ucode_t                word,
    output irenc_pkg::dp_ctrl_t                   ctrl,
    input  wire irenc_pkg::dp_status_t            status,
    output logic                                  char_valid,
    input  wire logic                             char_stall,
    output logic [irenc_pkg::SYMBOL_W-1:0]        symbol,
    output logic                                  last
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FIRST  = 3'b010,
        S_SECOND = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [irenc_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic                            out_valid_reg, out_valid_next;
    logic [irenc_pkg::SYMBOL_W-1:0]  symbol_reg, symbol_next;
    logic                            last_reg, last_next;
    logic                            out_free;
    logic                            accept;
    logic                            emit;

    assign out_free   = !out_valid_reg || !char_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ctrl        = '0;
        emit        = 1'b0;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load = 1'b1;
                    pc_next   = '0;
                    if (!value_zero)
                    begin
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                if (status.ge)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        ctrl.sub    = 1'b1;
                        symbol_next = word.first;
                        last_next   = status.diff_zero && !word.pair;
                        if (word.pair)
                        begin
                            state_next = S_SECOND;
                        end
                        else if (status.diff_zero)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (!word.final_step)
                begin
                    // weight does not fit: fall through to the next step
                    pc_next = pc_reg + 1'b1;
                end
            end
            S_SECOND:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    symbol_next = word.second;
                    last_next   = status.rest_zero;
                    state_next  = status.rest_zero ? S_IDLE : S_FIRST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!char_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    assign pc         = pc_reg;
    assign char_valid = out_valid_reg;
    assign symbol     = symbol_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// testbench for the integer to roman numeral encoder: directed table, random numbers, stalls
`default_nettype none

module tb_top;

    import irenc_pkg::*;

    localparam int DIR_N      = 24;
    localparam int RAND_N     = 76;
    localparam int QUIET_N    = 20;        // final random items run with no idling
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 40;        // extra wait after the expected letters have drained

    typedef logic [SYMBOL_W-1:0] letter_q_t [$];

    // one expected output item: a letter and its end-of-numeral flag
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } roman_char_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [VALUE_W-1:0]  value = '0;
    logic                char_valid;
    logic                char_stall = 1'b0;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;

    roman_char_t pending_chars [$];
    int          fault_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    // greedy subtraction steps: weight, first letter, second letter of a subtractive pair
    int unsigned         step_weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                              10, 9, 5, 4, 1};
    logic [SYMBOL_W-1:0] step_first  [13] = '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L,
                                              CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
    logic [SYMBOL_W-1:0] step_second [13] = '{CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C,
                                              CH_NONE, CH_L, CH_NONE, CH_X, CH_NONE, CH_V,
                                              CH_NONE};

    // directed numbers; "?" means the letters come from the predictor
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50,
        12'd90, 12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3888, 12'd3999,
        12'd4000, 12'd4095, 12'd2048, 12'd1994, 12'd444, 12'd2730, 12'd1365, 12'd0
    };
    string dir_spell [DIR_N] = '{
        "", "I", "IV", "?", "IX", "?", "?", "?",
        "?", "?", "?", "?", "?", "M", "MMMDCCCLXXXVIII", "MMMCMXCIX",
        "MMMM", "MMMMXCV", "?", "?", "?", "?", "?", ""
    };

    integer_to_roman_encoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .symbol     (symbol),
        .last       (last)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d letters outstanding",
                     cycle_count, pending_chars.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    // letters of the numeral for n, greedy over the step table, capped at 15
    function automatic void roman_spelling(input logic [VALUE_W-1:0] n,
                                           output letter_q_t letters);
        int unsigned rest;
        int          k;
        rest = n;
        letters = {};
        for (k = 0; k < 13; k++)
        begin
            while (rest >= step_weight[k] && letters.size() < 15)
            begin
                rest -= step_weight[k];
                letters.push_back(step_first[k]);
                if (step_second[k] != CH_NONE && letters.size() < 15)
                    letters.push_back(step_second[k]);
            end
        end
    endfunction

    // queue the letters of one number, flagging the final one
    function automatic void book_numeral(input letter_q_t letters);
        roman_char_t c;
        int          i;
        for (i = 0; i < letters.size(); i++)
        begin
            c.symbol = letters[i];
            c.last   = (i == letters.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // offer one number and return at the edge where it is taken
    task automatic offer_number(input logic [VALUE_W-1:0] n);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= n;
        do @(posedge clk); while (item_stall);
    endtask

    // random number, weighted toward numerals with many letters and every digit pattern
    function automatic logic [VALUE_W-1:0] pick_number();
        int unsigned pick;
        int unsigned heavy [3] = '{3, 7, 8};
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return VALUE_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                                       + $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
            4:          return VALUE_W'($urandom_range(0, 49));
            5:          return VALUE_W'($urandom_range(4000, 4095));
            8:          return VALUE_W'($urandom_range(0, 3) * 1000
                                       + heavy[$urandom_range(0, 2)] * 100
                                       + heavy[$urandom_range(0, 2)] * 10
                                       + heavy[$urandom_range(0, 2)]);
            default:    return VALUE_W'($urandom());
        endcase
    endfunction

    // output stall: random bursts, none in the quiet tail
    always @(posedge clk)
    begin
        if (quiet)
        begin
            stall_left <= 0;
            char_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            char_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            char_stall <= 1'b1;
        end
        else
            char_stall <= 1'b0;
    end

    // letter checker: every taken item against the oldest expected letter
    always @(posedge clk)
    begin
        roman_char_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            if (pending_chars.size() == 0)
                report_fault($sformatf("unexpected letter %h last %b", symbol, last));
            else
            begin
                want = pending_chars.pop_front();
                if (symbol !== want.symbol || last !== want.last)
                    report_fault($sformatf("expected letter %h last %b, got %h last %b",
                                           want.symbol, want.last, symbol, last));
            end
        end
    end

    // stimulus
    initial
    begin
        letter_q_t          letters;
        logic [VALUE_W-1:0] n;
        int                 k;
        int                 i;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: typed spelling where given, predictor elsewhere
        for (k = 0; k < DIR_N; k++)
        begin
            offer_number(dir_value[k]);
            if (dir_spell[k] == "?")
                roman_spelling(dir_value[k], letters);
            else
            begin
                letters = {};
                for (i = 0; i < dir_spell[k].len(); i++)
                    letters.push_back(dir_spell[k][i]);
            end
            book_numeral(letters);
        end

        // hold off until the block has emitted everything
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);

        // random numbers, idling dropped for the tail
        for (k = 0; k < RAND_N; k++)
        begin
            if (k == RAND_N - QUIET_N)
                quiet <= 1'b1;
            n = pick_number();
            offer_number(n);
            roman_spelling(n, letters);
            book_numeral(letters);
        end

        item_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_chars.size() != 0)
            report_fault($sformatf("%0d letters never arrived", pending_chars.size()));

        if (fault_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
